/* sv/b64lc_pkg.sv */
// package: shared types, character codes and the alphabet decoder
`default_nettype none

package b64lc_pkg;

  // character codes
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  // symbol value offsets
  localparam logic [7:0] OFS_LOWER = 8'd26;
  localparam logic [7:0] OFS_DIGIT = 8'd52;
  localparam logic [5:0] VAL_PLUS  = 6'd62;
  localparam logic [5:0] VAL_SLASH = 6'd63;

  // symbol counts (modulo 4) after which padding may start
  localparam logic [1:0] CNT_SINGLE_PAD = 2'd3;
  localparam logic [1:0] CNT_DOUBLE_PAD = 2'd2;

  // padding progress
  typedef enum logic [1:0] {
    PAD_NONE  = 2'd0,
    PAD_FIRST = 2'd1,
    PAD_SPACE = 2'd2,
    PAD_DONE  = 2'd3
  } pad_phase_t;

  // lexer state carried from word to word
  typedef struct packed {
    logic       prev_was_space;
    logic [5:0] last_symbol_value;
    logic [1:0] symbol_count_mod4;
    pad_phase_t pad_phase;
    logic       error_seen;
    logic       seen_char;
  } lex_state_t;

  localparam lex_state_t STATE_RESET = '{
    prev_was_space:    1'b1,
    last_symbol_value: 6'd0,
    symbol_count_mod4: 2'd0,
    pad_phase:         PAD_NONE,
    error_seen:        1'b0,
    seen_char:         1'b0
  };

  // one result word
  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       done;
    logic       ok;
  } lex_res_t;

  // decoded alphabet symbol
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sym_t;

  // map a byte to its 6-bit alphabet value
  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t       s;
    logic [7:0] d;
    s = '0;
    d = 8'd0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
      s.valid = 1'b1;
      s.value = d[5:0];
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + OFS_LOWER;
      s.valid = 1'b1;
      s.value = d[5:0];
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0 + OFS_DIGIT;
      s.valid = 1'b1;
      s.value = d[5:0];
    end else if (c == CH_PLUS) begin
      s.valid = 1'b1;
      s.value = VAL_PLUS;
    end else if (c == CH_SLASH) begin
      s.valid = 1'b1;
      s.value = VAL_SLASH;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/b64lc_step.sv */
// step logic: one character against the lexer state, next state and result word
`default_nettype none

module b64lc_step (
  input  wire logic [7:0]            ch,
  input  wire logic                  present,
  input  wire logic                  last,
  input  wire b64lc_pkg::lex_state_t st,
  output b64lc_pkg::lex_state_t      st_nxt,
  output b64lc_pkg::lex_res_t        res
);
  import b64lc_pkg::*;

  always_comb begin
    lex_state_t upd;
    sym_t       sym;
    logic       keep;
    upd  = st;
    sym  = sym_decode(ch);
    keep = 1'b0;

    // character rules
    if (present && !st.error_seen) begin
      upd.seen_char = 1'b1;
      unique case (st.pad_phase)
        PAD_DONE: begin
          upd.error_seen = 1'b1;
        end
        PAD_FIRST: begin
          if (ch == CH_PAD) begin
            keep = 1'b1;
            upd.pad_phase = PAD_DONE;
          end else if (ch == CH_SPACE) begin
            upd.pad_phase = PAD_SPACE;
          end else begin
            upd.error_seen = 1'b1;
          end
        end
        PAD_SPACE: begin
          if (ch == CH_PAD) begin
            keep = 1'b1;
            upd.pad_phase = PAD_DONE;
          end else begin
            upd.error_seen = 1'b1;
          end
        end
        PAD_NONE: begin
          priority if (ch == CH_SPACE) begin
            if (st.prev_was_space) upd.error_seen = 1'b1;
            else upd.prev_was_space = 1'b1;
          end else if (ch == CH_PAD) begin
            // symbol before the pad must be in the 16 or 4 symbol class
            priority if (st.symbol_count_mod4 == CNT_SINGLE_PAD &&
                         st.last_symbol_value[1:0] == 2'd0) begin
              keep = 1'b1;
              upd.pad_phase = PAD_DONE;
            end else if (st.symbol_count_mod4 == CNT_DOUBLE_PAD &&
                         st.last_symbol_value[3:0] == 4'd0) begin
              keep = 1'b1;
              upd.pad_phase = PAD_FIRST;
            end else begin
              upd.error_seen = 1'b1;
            end
            upd.prev_was_space = 1'b0;
          end else if (sym.valid) begin
            keep = 1'b1;
            upd.last_symbol_value = sym.value;
            upd.symbol_count_mod4 = st.symbol_count_mod4 + 2'd1;
            upd.prev_was_space = 1'b0;
          end else begin
            upd.error_seen = 1'b1;
          end
        end
        default: begin
          upd.error_seen = 1'b1;
        end
      endcase
    end

    // result word
    res.ch      = keep ? ch : 8'd0;
    res.present = keep;
    res.done    = last;
    res.ok      = 1'b0;

    // end of string verdict, then back to string start
    if (last) begin
      priority if (!upd.seen_char) begin
        res.ok = 1'b1;
      end else if (upd.error_seen) begin
        res.ok = 1'b0;
      end else if (upd.pad_phase == PAD_DONE) begin
        res.ok = 1'b1;
      end else if (upd.pad_phase == PAD_NONE) begin
        res.ok = !upd.prev_was_space && (upd.symbol_count_mod4 == 2'd0);
      end else begin
        res.ok = 1'b0;
      end
      st_nxt = STATE_RESET;
    end else begin
      st_nxt = upd;
    end
  end

endmodule

`default_nettype wire

/* sv/base64_lexical_check_canonicalize.sv */
// top level: input register, lexer state register and result register
`default_nettype none

// Checks a base64 text against the XML Schema base64Binary lexical rules,
// one character per word, and passes on its canonical form with spaces
// dropped. Every input word gives exactly one result word; the verdict
// comes on the word marked last, and the lexer then restarts for a new
// string. The block takes one word per clock cycle while the result
// register is not stalled: a word is held in the input register, run
// through the step logic against the state register, and lands in the
// result register. The throughput is set by the single state register
// update per cycle, held while the result register is stalled and full;
// a word waiting in the input register then raises in_stall.

module base64_lexical_check_canonicalize (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_char_present,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_present,
  output logic            out_done_res,
  output logic            out_verdict_ok
);
  import b64lc_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] char_r;
  logic       present_r;
  logic       last_r;
  logic       out_valid_r, out_valid_nxt;
  lex_res_t   res_r;
  lex_state_t state_r, state_nxt;
  lex_res_t   res_nxt;
  logic       out_free;
  logic       advance;
  logic       load_in;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign load_in  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = load_in || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  // step logic
  b64lc_step u_step (
    .ch      (char_r),
    .present (present_r),
    .last    (last_r),
    .st      (state_r),
    .st_nxt  (state_nxt),
    .res     (res_nxt)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) state_r <= state_nxt;
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (load_in) begin
      char_r    <= in_char;
      present_r <= in_char_present;
      last_r    <= in_is_last;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char       = res_r.ch;
  assign out_present    = res_r.present;
  assign out_done_res   = res_r.done;
  assign out_verdict_ok = res_r.ok;

endmodule

`default_nettype wire
